FILE: sv/rce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rce_pkg
// Shared types and constants of the range coder encoder.
// ----------------------------------------------------------------------------
package rce_pkg;

  localparam logic [31:0] TopLimit  = 32'h0100_0000;
  localparam logic [31:0] BotLimit  = 32'h0001_0000;
  localparam logic [31:0] FullRange = 32'hFFFF_FFFF;
  localparam logic [16:0] MaxTotal  = 17'h10000;
  localparam int          QueueDepth = 2;

  typedef enum logic [1:0] {
    OP_ENCODE,
    OP_FLUSH,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] cum_low;
    logic [16:0] sym_freq;
    logic [16:0] total_freq;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_NORM,
    ST_FLUSH,
    ST_BAD
  } state_t;

endpackage
`default_nettype wire

FILE: sv/rce_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rce_front
// Accept input transactions, check frequencies and queue classified commands.
// ----------------------------------------------------------------------------
module rce_front #(
  parameter int Depth = rce_pkg::QueueDepth
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          action,
  input  wire logic [15:0]   cum_low,
  input  wire logic [16:0]   sym_freq,
  input  wire logic [16:0]   total_freq,
  output logic               cmd_valid,
  input  wire logic          cmd_ready,
  output rce_pkg::cmd_t      cmd
);

  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

  rce_pkg::cmd_t  mem [Depth];
  logic [Aw-1:0]  wr_ptr;
  logic [Aw-1:0]  rd_ptr;
  logic [Aw:0]    count;
  rce_pkg::cmd_t  cls;
  logic           bad;
  logic           push;
  logic           pop;

  always_comb begin
    bad = (sym_freq == 17'd0) || (total_freq == 17'd0) ||
          (total_freq > rce_pkg::MaxTotal) ||
          ({2'b00, cum_low} + {1'b0, sym_freq} > {1'b0, total_freq});
    cls.cum_low    = cum_low;
    cls.sym_freq   = sym_freq;
    cls.total_freq = total_freq;
    if (action) begin
      cls.op = rce_pkg::OP_FLUSH;
    end else if (bad) begin
      cls.op = rce_pkg::OP_BAD;
    end else begin
      cls.op = rce_pkg::OP_ENCODE;
    end
  end

  assign in_ready  = (count != (Aw+1)'(Depth));
  assign cmd_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Aw'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Aw'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (Aw+1)'(Depth)) else $error("queue overfilled");
  a_push_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> !push) else $error("push into full queue");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1) else $error("count slip");

endmodule
`default_nettype wire

FILE: sv/rce_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rce_back
// Divide, narrow and renormalise the interval, flush and flag bad items; emit bytes through a register.
// ----------------------------------------------------------------------------
module rce_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  rce_pkg::cmd_t      cmd,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               last,
  output logic               bad_input
);

  rce_pkg::state_t state, state_next;
  logic [31:0] low_bound, low_bound_next;
  logic [31:0] range_width, range_width_next;
  logic [31:0] quot, quot_next;
  logic [16:0] rem, rem_next;
  logic [5:0]  bit_cnt, bit_cnt_next;
  logic [2:0]  n_cnt, n_cnt_next;
  rce_pkg::cmd_t cur, cur_next;
  logic        out_valid_next;
  logic [7:0]  out_byte_next;
  logic        last_next, bad_next;

  logic        slot_free;
  logic [17:0] trial;
  logic [31:0] sum_hi;
  logic        top_eq, small_rng, more;
  logic [31:0] rng_eff;
  logic [31:0] low_sh;
  logic [31:0] rng_sh;

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    trial     = {rem, quot[31]} - {1'b0, cur.total_freq};
    sum_hi    = low_bound + range_width;
    top_eq    = (low_bound ^ sum_hi) < rce_pkg::TopLimit;
    small_rng = range_width < rce_pkg::BotLimit;
    rng_eff   = top_eq ? range_width : {16'd0, 16'(32'd0 - low_bound)};
    low_sh    = {low_bound[23:0], 8'd0};
    rng_sh    = {rng_eff[23:0], 8'd0};
    more      = ((low_sh ^ (low_sh + rng_sh)) < rce_pkg::TopLimit) ||
                (rng_sh < rce_pkg::BotLimit);
  end

  always_comb begin
    state_next       = state;
    low_bound_next   = low_bound;
    range_width_next = range_width;
    quot_next        = quot;
    rem_next         = rem;
    bit_cnt_next     = bit_cnt;
    n_cnt_next       = n_cnt;
    cur_next         = cur;
    out_valid_next   = out_valid && !out_ready;
    out_byte_next    = out_byte;
    last_next        = last;
    bad_next         = bad_input;
    cmd_ready        = 1'b0;
    unique case (state)
      rce_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cur_next     = cmd;
          quot_next    = range_width;
          rem_next     = '0;
          bit_cnt_next = '0;
          n_cnt_next   = '0;
          unique case (cmd.op)
            rce_pkg::OP_ENCODE: state_next = rce_pkg::ST_DIV;
            rce_pkg::OP_FLUSH:  state_next = rce_pkg::ST_FLUSH;
            default:            state_next = rce_pkg::ST_BAD;
          endcase
        end
      end
      rce_pkg::ST_DIV: begin
        if (!trial[17]) begin
          rem_next  = trial[16:0];
          quot_next = {quot[30:0], 1'b1};
        end else begin
          rem_next  = {rem[15:0], quot[31]};
          quot_next = {quot[30:0], 1'b0};
        end
        bit_cnt_next = bit_cnt + 1'b1;
        if (bit_cnt == 6'd31) begin
          state_next = rce_pkg::ST_MUL;
        end
      end
      rce_pkg::ST_MUL: begin
        low_bound_next   = low_bound + 32'(quot * {16'd0, cur.cum_low});
        range_width_next = 32'(quot * {15'd0, cur.sym_freq});
        state_next       = rce_pkg::ST_NORM;
      end
      rce_pkg::ST_NORM: begin
        if (!(top_eq || small_rng)) begin
          state_next = rce_pkg::ST_IDLE;
        end else if (slot_free) begin
          out_valid_next   = 1'b1;
          out_byte_next    = low_bound[31:24];
          bad_next         = 1'b0;
          last_next        = !more || (n_cnt == 3'd3);
          low_bound_next   = low_sh;
          range_width_next = rng_sh;
          n_cnt_next       = n_cnt + 1'b1;
          if (last_next) begin
            state_next = rce_pkg::ST_IDLE;
          end
        end
      end
      rce_pkg::ST_FLUSH: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_byte_next  = low_bound[31:24];
          bad_next       = 1'b0;
          last_next      = (n_cnt == 3'd3);
          low_bound_next = low_sh;
          n_cnt_next     = n_cnt + 1'b1;
          if (n_cnt == 3'd3) begin
            low_bound_next   = '0;
            range_width_next = rce_pkg::FullRange;
            state_next       = rce_pkg::ST_IDLE;
          end
        end
      end
      rce_pkg::ST_BAD: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_byte_next  = 8'd0;
          bad_next       = 1'b1;
          last_next      = 1'b1;
          state_next     = rce_pkg::ST_IDLE;
        end
      end
      default: state_next = rce_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rce_pkg::ST_IDLE;
      low_bound   <= '0;
      range_width <= rce_pkg::FullRange;
      out_valid   <= 1'b0;
      n_cnt       <= '0;
      bit_cnt     <= '0;
    end else begin
      state       <= state_next;
      low_bound   <= low_bound_next;
      range_width <= range_width_next;
      out_valid   <= out_valid_next;
      n_cnt       <= n_cnt_next;
      bit_cnt     <= bit_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    quot      <= quot_next;
    rem       <= rem_next;
    cur       <= cur_next;
    out_byte  <= out_byte_next;
    last      <= last_next;
    bad_input <= bad_next;
  end

  a_bad_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_input |-> last) else $error("error result not last");
  a_idle_take: assert property (@(posedge clk) disable iff (rst)
    cmd_ready |-> state == rce_pkg::ST_IDLE) else $error("command taken while busy");
  a_flush_reset: assert property (@(posedge clk) disable iff (rst)
    (state == rce_pkg::ST_FLUSH && slot_free && n_cnt == 3'd3) |=>
    range_width == rce_pkg::FullRange && low_bound == '0) else $error("flush restore");

endmodule
`default_nettype wire

FILE: sv/range_coder_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// range_coder_encoder
// Carryless 32-bit range encoder.
// ----------------------------------------------------------------------------
// s_axis carries one item per transaction: tuser is the action (0 encode,
// 1 flush), tdata holds cum_low, sym_freq and total_freq. m_axis carries one
// compressed byte per transaction in tdata, tuser flags a bad item, tlast
// marks the final result of an item. The back takes a command while idle;
// an encode item then runs the bit-serial restoring divider by total_freq,
// the multiplies and the renormalisation, which emits 0 to 4 bytes. A
// flush emits four bytes, a bad item one. Items are handled one after
// another. A two-entry command queue sits between the checking front and
// the arithmetic back, so input is taken while the back works. Results sit
// in an output register; when the receiver stalls the back holds, then the
// queue fills and s_axis_tready drops. Reset sets low to 0, range to all
// ones and empties the queue and the output register.
// ----------------------------------------------------------------------------
module range_coder_encoder #(
  parameter int QueueDepth = rce_pkg::QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // cum_low[15:0], sym_freq[32:16], total_freq[49:33]
  input  wire logic        s_axis_tuser,  // action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // out_byte
  output logic             m_axis_tlast,  // last
  output logic             m_axis_tuser   // bad_input
);

  logic          cmd_valid;
  logic          cmd_ready;
  rce_pkg::cmd_t cmd;

  rce_front #(.Depth(QueueDepth)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .action     (s_axis_tuser),
    .cum_low    (s_axis_tdata[15:0]),
    .sym_freq   (s_axis_tdata[32:16]),
    .total_freq (s_axis_tdata[49:33]),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  rce_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .last      (m_axis_tlast),
    .bad_input (m_axis_tuser)
  );

endmodule
`default_nettype wire
